### sv/phase_to_circle_point_top_defines.svh
// Assertion macros shared by the phase-to-circle-point checker.
// Needs no other file; included by the checker module only.
`ifndef PHASE_TO_CIRCLE_POINT_TOP_DEFINES_SVH
`define PHASE_TO_CIRCLE_POINT_TOP_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define P2CP_ASSERT_HOLD(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// When the first condition holds, the second must hold in the next cycle.
`define P2CP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

### sv/p2cp_pkg.sv
// Types and constants of the phase-to-circle-point pipeline.
// Depends on nothing; imported by phase_to_circle_point_top.
package p2cp_pkg;

  // Angles are unsigned Q0.30 values and series terms unsigned Q1.30 values.
  localparam int unsigned FRAC_BITS = 30;

  // round(pi * 2^32), split in two halves for two narrow multipliers.
  localparam logic [33:0] PI_Q32     = 34'd13493037705;
  localparam int unsigned PI_LO_BITS = 17;
  localparam logic [16:0] PI_LO      = PI_Q32[16:0];
  localparam logic [16:0] PI_HI      = PI_Q32[33:17];

  localparam int unsigned SIN_STEPS = 5;
  localparam int unsigned COS_STEPS = 6;

  typedef logic [2:0]           octant_t;
  typedef logic [FRAC_BITS-1:0] ang_t;
  typedef logic [FRAC_BITS:0]   q30_t;

  localparam q30_t Q30_ONE = q30_t'(1) << FRAC_BITS;

  // Everything one series stage carries.
  typedef struct packed {
    octant_t oct;
    ang_t    x;
    ang_t    x2;
    q30_t    bs;
    q30_t    bc;
    ang_t    ts;
    ang_t    tc;
  } hstage_t;

  // Divisors of the sine series, innermost term first.
  function automatic logic [7:0] sin_divisor(input logic [2:0] step);
    logic [7:0] d;
    unique case (step)
      3'd0:    d = 8'd110;
      3'd1:    d = 8'd72;
      3'd2:    d = 8'd42;
      3'd3:    d = 8'd20;
      3'd4:    d = 8'd6;
      default: d = 8'd1;
    endcase
    return d;
  endfunction

  // Divisors of the cosine series, innermost term first.
  function automatic logic [7:0] cos_divisor(input logic [2:0] step);
    logic [7:0] d;
    unique case (step)
      3'd0:    d = 8'd132;
      3'd1:    d = 8'd90;
      3'd2:    d = 8'd56;
      3'd3:    d = 8'd30;
      3'd4:    d = 8'd12;
      3'd5:    d = 8'd2;
      default: d = 8'd1;
    endcase
    return d;
  endfunction

endpackage

### sv/phase_to_circle_point_top.sv
// Pipelined sine/cosine unit that maps a phase key to a point on a circle of radius 0.99.
// Depends on p2cp_pkg for types, series divisors and the pi constant.
//
// Each accepted phase key yields one (horizontal, vertical) pair of signed
// fixed-point values, 0.99*sin and 0.99*cos of the phase, where key 0 is the
// top of the circle and the phase turns clockwise. The unit is a 19-stage
// pipeline: octant folding, angle scaling and squaring take three stages,
// each of the six Horner steps of the series takes two (a multiply, then a
// divide by a constant done as a reciprocal multiply), and scaling, rounding
// and sign take four. A key can be accepted in every cycle while the output
// side is ready. Every stage has its own valid bit and holds its item while
// the next stage is full and stalled, so a stalled output only stops the
// stages behind it once they fill up and bubbles are squeezed out.
module phase_to_circle_point_top #(
  parameter int unsigned PHASE_BITS = 32,
  parameter int unsigned OUT_BITS   = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [31:0]         phase_key_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [OUT_BITS-1:0] horizontal_o,
  output logic [OUT_BITS-1:0] vertical_o
);
  import p2cp_pkg::*;

  localparam int unsigned F          = FRAC_BITS;
  localparam int unsigned PAD        = 32 - PHASE_BITS;
  localparam int unsigned H_REGS     = 2 * COS_STEPS + 1;
  localparam int unsigned NUM_STAGES = 2 + 2 * COS_STEPS + 5;
  localparam int unsigned ST_H       = 3 + 2 * COS_STEPS;
  // Width of the rounded value before the final divide by 100.
  localparam int unsigned UW         = OUT_BITS + 6;
  localparam int unsigned KR         = UW + 7;
  localparam logic [63:0] RC         = ((64'd1 << KR) + 64'd99) / 64'd100;
  localparam logic [OUT_BITS-1:0] TOP = {1'b0, {(OUT_BITS-1){1'b1}}};

  // Handshake chain: a stage may load when it is empty or its item moves on.
  logic [NUM_STAGES-1:0] v_q, v_d;
  logic [NUM_STAGES:0]   adv;

  assign adv[NUM_STAGES] = out_ready_i;
  for (genvar i = 0; i < NUM_STAGES; i++) begin : g_adv
    assign adv[i] = !v_q[i] || adv[i+1];
    if (i == 0) begin : g_first
      assign v_d[i] = adv[i] ? in_valid_i : v_q[i];
    end else begin : g_rest
      assign v_d[i] = adv[i] ? v_q[i-1] : v_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = v_q[NUM_STAGES-1];

  // Stage 0: fold the phase into one octant and multiply by both halves of pi.
  logic [31:0]        p_w;
  octant_t            oct_w;
  logic [F-1:0]       g_w;
  octant_t            oct0_q;
  logic [F+16:0]      gph_q, gpl_q;

  always_comb begin
    p_w   = 32'(phase_key_i[PHASE_BITS-1:0]) << PAD;
    oct_w = p_w[31:29];
    // Odd octants run backwards from 45 degrees.
    if (oct_w[0]) begin
      g_w = 30'h2000_0000 - {1'b0, p_w[28:0]};
    end else begin
      g_w = {1'b0, p_w[28:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      oct0_q <= oct_w;
      gph_q  <= (F+17)'(g_w) * (F+17)'(PI_HI);
      gpl_q  <= (F+17)'(g_w) * (F+17)'(PI_LO);
    end
  end

  // Stage 1: combine the partial products into the angle in radians.
  logic [63:0] xsum_w;
  octant_t     oct1_q;
  ang_t        x1_q;

  assign xsum_w = {gph_q, {PI_LO_BITS{1'b0}}} + 64'(gpl_q) + (64'd1 << 32);

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      oct1_q <= oct0_q;
      x1_q   <= xsum_w[F+32:33];
    end
  end

  // Stage 2: square of the angle, rounded; both series start at one.
  hstage_t     hq [H_REGS];
  logic [2*F:0] xx_w;

  assign xx_w = {1'b0, (2*F)'(x1_q) * (2*F)'(x1_q)} + ((2*F+1)'(1) << (F-1));

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      hq[0].oct <= oct1_q;
      hq[0].x   <= x1_q;
      hq[0].x2  <= xx_w[2*F-1:F];
      hq[0].bs  <= Q30_ONE;
      hq[0].bc  <= Q30_ONE;
      hq[0].ts  <= '0;
      hq[0].tc  <= '0;
    end
  end

  // Horner steps: b <- 1 - (x2*b)/n, two stages each.
  for (genvar j = 0; j < COS_STEPS; j++) begin : g_step
    localparam int unsigned DS = (j < SIN_STEPS) ? sin_divisor(3'(j)) : 1;
    localparam int unsigned DC = cos_divisor(3'(j));
    localparam int unsigned KS = F + $clog2(DS);
    localparam int unsigned KC = F + $clog2(DC);
    // Rounded-up reciprocals; exact for every dividend below 2^30.
    localparam logic [63:0] MS = ((64'd1 << KS) + 64'(DS) - 64'd1) / 64'(DS);
    localparam logic [63:0] MC = ((64'd1 << KC) + 64'(DC) - 64'd1) / 64'(DC);

    logic [2*F:0] ps_w, pc_w, qs_w, qc_w;
    hstage_t      a_d, b_d;

    always_comb begin
      ps_w    = (2*F+1)'(hq[2*j].x2) * (2*F+1)'(hq[2*j].bs);
      pc_w    = (2*F+1)'(hq[2*j].x2) * (2*F+1)'(hq[2*j].bc);
      a_d     = hq[2*j];
      a_d.ts  = ps_w[2*F-1:F];
      a_d.tc  = pc_w[2*F-1:F];
    end

    always_comb begin
      qs_w   = (2*F+1)'(hq[2*j+1].ts) * (2*F+1)'(MS[F:0]);
      qc_w   = (2*F+1)'(hq[2*j+1].tc) * (2*F+1)'(MC[F:0]);
      b_d    = hq[2*j+1];
      b_d.bc = Q30_ONE - q30_t'(qc_w >> KC);
      if (j < SIN_STEPS) begin
        b_d.bs = Q30_ONE - q30_t'(qs_w >> KS);
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[3+2*j]) begin
        hq[2*j+1] <= a_d;
      end
      if (adv[4+2*j]) begin
        hq[2*j+2] <= b_d;
      end
    end
  end

  // Final sine term times the angle.
  hstage_t      hf_w;
  logic [2*F:0] sx_w;
  octant_t      octh_q;
  q30_t         sq_q, cq_q;

  assign hf_w = hq[H_REGS-1];
  assign sx_w = (2*F+1)'(hf_w.x) * (2*F+1)'(hf_w.bs);

  always_ff @(posedge clk_i) begin
    if (adv[ST_H]) begin
      octh_q <= hf_w.oct;
      sq_q   <= sx_w[2*F:F];
      cq_q   <= hf_w.bc;
    end
  end

  // Octant picks which series feeds which axis and the signs.
  // Scale by 99 and by the output range, add half of the divisor.
  logic            swap_w;
  q30_t            sv_w, cv_w;
  logic [63:0]     ys_w, yc_w;
  logic [UW-1:0]   us_q, uc_q;
  logic            sneg1_q, cneg1_q;

  function automatic logic [63:0] scale99(input q30_t v);
    logic [63:0] w;
    w = 64'(v);
    return ((w << 6) + (w << 5) + (w << 1) + w) << (OUT_BITS - 1);
  endfunction

  always_comb begin
    swap_w = octh_q[0] ^ octh_q[1];
    sv_w   = swap_w ? cq_q : sq_q;
    cv_w   = swap_w ? sq_q : cq_q;
    ys_w   = scale99(sv_w) + (64'd50 << F);
    yc_w   = scale99(cv_w) + (64'd50 << F);
  end

  always_ff @(posedge clk_i) begin
    if (adv[ST_H+1]) begin
      us_q    <= UW'(ys_w >> F);
      uc_q    <= UW'(yc_w >> F);
      sneg1_q <= octh_q[2];
      cneg1_q <= octh_q[2] ^ octh_q[1];
    end
  end

  // Divide by 100 through its reciprocal.
  logic [2*UW:0]       ds_w, dc_w;
  logic [OUT_BITS-1:0] ms_q, mc_q;
  logic                sneg2_q, cneg2_q;

  assign ds_w = (2*UW+1)'(us_q) * (2*UW+1)'(RC[UW:0]);
  assign dc_w = (2*UW+1)'(uc_q) * (2*UW+1)'(RC[UW:0]);

  always_ff @(posedge clk_i) begin
    if (adv[ST_H+2]) begin
      ms_q    <= OUT_BITS'(ds_w >> KR);
      mc_q    <= OUT_BITS'(dc_w >> KR);
      sneg2_q <= sneg1_q;
      cneg2_q <= cneg1_q;
    end
  end

  // Clamp to full scale and apply the sign.
  logic [OUT_BITS-1:0] ks_w, kc_w;
  logic [OUT_BITS-1:0] horizontal_q, vertical_q;

  always_comb begin
    ks_w = (ms_q > TOP) ? TOP : ms_q;
    kc_w = (mc_q > TOP) ? TOP : mc_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv[ST_H+3]) begin
      horizontal_q <= sneg2_q ? -ks_w : ks_w;
      vertical_q   <= cneg2_q ? -kc_w : kc_w;
    end
  end

  assign horizontal_o = horizontal_q;
  assign vertical_o   = vertical_q;

endmodule

### sv/p2cp_checker.sv
// Port-level checks of the phase-to-circle-point unit, bound to its top level.
// Depends on phase_to_circle_point_top_defines.svh for the assertion macros.
`include "phase_to_circle_point_top_defines.svh"

module p2cp_checker #(
  parameter int unsigned OUT_BITS = 16
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic [31:0]         phase_key_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic [OUT_BITS-1:0] horizontal_o,
  input logic [OUT_BITS-1:0] vertical_o
);

  // On a circle of radius 0.99 one coordinate is always at least 0.7 in size.
  localparam logic [OUT_BITS-1:0] THRESH = OUT_BITS'((64'd7 << (OUT_BITS - 1)) / 64'd10);
  localparam logic [OUT_BITS-1:0] MOST_NEG = {1'b1, {(OUT_BITS-1){1'b0}}};

  logic [OUT_BITS-1:0] habs, vabs;
  logic                big_coord;
  logic                no_most_neg;

  assign habs        = horizontal_o[OUT_BITS-1] ? -horizontal_o : horizontal_o;
  assign vabs        = vertical_o[OUT_BITS-1] ? -vertical_o : vertical_o;
  assign big_coord   = (habs >= THRESH) || (vabs >= THRESH);
  assign no_most_neg = (horizontal_o != MOST_NEG) && (vertical_o != MOST_NEG);

  `P2CP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(horizontal_o) && $stable(vertical_o), "output transaction changed while stalled")
  `P2CP_ASSERT_NEXT(a_in_hold, clk_i, rst_ni, in_valid_i && !in_ready_o, in_valid_i && $stable(phase_key_i), "input transaction changed while stalled")
  `P2CP_ASSERT_HOLD(a_on_circle, clk_i, rst_ni, out_valid_o |-> big_coord, "result point lies far inside the circle")
  `P2CP_ASSERT_HOLD(a_range, clk_i, rst_ni, out_valid_o |-> no_most_neg, "result coordinate beyond full scale")

endmodule

bind phase_to_circle_point_top p2cp_checker #(.OUT_BITS(OUT_BITS)) u_p2cp_checker (.*);

### tb/phase_to_circle_point_top_test.sv
// Self-checking testbench of phase_to_circle_point_top, the pipelined 0.99*sin/cos unit.
// Needs only the block and its package; an integer predictor sets the untyped points.
// A directed key table comes first, then random keys; both sides idle and stall at random.
module phase_to_circle_point_top_test;

  localparam int unsigned IDLE_LIMIT  = 2000;
  localparam int unsigned RANDOM_KEYS = 1250;
  localparam int unsigned DRAIN_WAIT  = 40;

  // round(pi * 2^32), and the series divisors with the innermost term in the low byte.
  localparam logic [63:0] PI_TURN_Q32 = 64'd13493037705;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
  localparam logic [39:0] SIN_DIVS    = {8'd6, 8'd20, 8'd42, 8'd72, 8'd110};
  localparam logic [47:0] COS_DIVS    = {8'd2, 8'd12, 8'd30, 8'd56, 8'd90, 8'd132};
  localparam logic [63:0] SCALE_DEN   = 64'd100 << 30;
  localparam logic [63:0] FULL_SCALE  = 64'd32767;

  typedef struct packed {
    logic [31:0]        key;
    logic signed [15:0] h;
    logic signed [15:0] v;
  } circle_pt_t;

  typedef struct packed {
    logic [31:0]        key;
    bit                 typed;
    logic signed [15:0] h;
    logic signed [15:0] v;
  } key_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [31:0] phase_key_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [15:0] horizontal_o;
  logic [15:0] vertical_o;

  circle_pt_t pending_points[$];
  circle_pt_t want;
  key_row_t   key_table[21];
  int unsigned n_fail = 0;
  int unsigned n_keys = 0;
  int unsigned n_points = 0;
  int unsigned idle_cycles = 0;
  bit          no_gaps = 1'b0;

  phase_to_circle_point_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .phase_key_i (phase_key_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .horizontal_o(horizontal_o),
    .vertical_o  (vertical_o)
  );

  always #5 clk_i = ~clk_i;

  // Unsigned Horner evaluation of the truncated sine or cosine series in Q2.30.
  function automatic logic [63:0] series_q30(input logic [63:0] x2, input bit cosine);
    logic [63:0] b;
    logic [63:0] d;
    int          n_terms;
    b = ONE_Q30;
    n_terms = cosine ? 6 : 5;
    for (int i = 0; i < n_terms; i++) begin
      d = cosine ? 64'(COS_DIVS[8*i +: 8]) : 64'(SIN_DIVS[8*i +: 8]);
      b = ONE_Q30 - ((x2 * b) >> 30) / d;
    end
    return b;
  endfunction

  // Scales a Q2.30 magnitude by 0.99 to Q1.15, rounds half up, clamps, applies the sign.
  function automatic logic [15:0] radius_q15(input logic [63:0] mag, input bit negative);
    logic [63:0] m;
    m = (((mag * 64'd99) << 15) + (SCALE_DEN >> 1)) / SCALE_DEN;
    if (m > FULL_SCALE) m = FULL_SCALE;
    if (negative) m = 64'd0 - m;
    return m[15:0];
  endfunction

  function automatic circle_pt_t circle_point(input logic [31:0] key);
    circle_pt_t  pt;
    int          oct;
    logic [63:0] f;
    logic [63:0] g;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] s;
    logic [63:0] c;
    bit          swap;
    oct = int'(key[31:29]);
    f = 64'(key[28:0]);
    // Odd octants fold the angle back from the 45 degree line.
    g = key[29] ? ((64'd1 << 29) - f) : f;
    x = (g * PI_TURN_Q32 + (64'd1 << 32)) >> 33;
    x2 = (x * x + (64'd1 << 29)) >> 30;
    s = (x * series_q30(x2, 1'b0)) >> 30;
    c = series_q30(x2, 1'b1);
    swap = (((oct + 1) >> 1) & 1) != 0;
    pt.key = key;
    pt.h = radius_q15(swap ? c : s, oct >= 4);
    pt.v = radius_q15(swap ? s : c, (((oct + 2) >> 2) & 1) != 0);
    return pt;
  endfunction

  // Mostly back to back, sometimes a few cycles, rarely a long pause.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_key(input logic [31:0] key, input circle_pt_t expected_pt);
    int unsigned gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    phase_key_i <= key;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_points.push_back(expected_pt);
    n_keys++;
  endtask

  task automatic wait_all_points();
    in_valid_i <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk_i);
  endtask

  // Output side: ready runs of random length, some followed by a stall.
  initial begin
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      out_ready_i <= 1'b1;
      if ($urandom_range(0, 19) == 0) repeat (300) @(posedge clk_i);
      else repeat ($urandom_range(1, 30)) @(posedge clk_i);
      stall = pick_gap();
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  // Every accepted point is compared with the oldest one still expected.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_points.size() == 0) begin
        $display("%0t: unexpected point h=%0d v=%0d", $time,
                 $signed(horizontal_o), $signed(vertical_o));
        n_fail++;
      end else begin
        want = pending_points.pop_front();
        n_points++;
        if (horizontal_o !== want.h) begin
          $display("%0t: key %h horizontal expected %0d, actual %0d", $time, want.key,
                   want.h, $signed(horizontal_o));
          n_fail++;
        end
        if (vertical_o !== want.v) begin
          $display("%0t: key %h vertical expected %0d, actual %0d", $time, want.key,
                   want.v, $signed(vertical_o));
          n_fail++;
        end
      end
    end
  end

  // Ends the run when neither side completes a transaction for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] key;
    circle_pt_t  pt;
    // The four axis points are exact: the series gives 0 and 1.0, which scale to 0 and 32440.
    key_table = '{
      '{32'h0000_0000, 1'b1, 16'sd0, 16'sd32440},
      '{32'h4000_0000, 1'b1, 16'sd32440, 16'sd0},
      '{32'h8000_0000, 1'b1, 16'sd0, -16'sd32440},
      '{32'hC000_0000, 1'b1, -16'sd32440, 16'sd0},
      '{32'hFFFF_FFFF, 1'b0, 16'sd0, 16'sd0},
      '{32'h0000_0001, 1'b0, 16'sd0, 16'sd0},
      '{32'h1FFF_FFFF, 1'b0, 16'sd0, 16'sd0},
      '{32'h2000_0000, 1'b0, 16'sd0, 16'sd0},
      '{32'h2000_0001, 1'b0, 16'sd0, 16'sd0},
      '{32'h3FFF_FFFF, 1'b0, 16'sd0, 16'sd0},
      '{32'h6000_0000, 1'b0, 16'sd0, 16'sd0},
      '{32'h7FFF_FFFF, 1'b0, 16'sd0, 16'sd0},
      '{32'h9FFF_FFFF, 1'b0, 16'sd0, 16'sd0},
      '{32'hA000_0000, 1'b0, 16'sd0, 16'sd0},
      '{32'hE000_0000, 1'b0, 16'sd0, 16'sd0},
      '{32'h5555_5555, 1'b0, 16'sd0, 16'sd0},
      '{32'hAAAA_AAAA, 1'b0, 16'sd0, 16'sd0},
      '{32'h1234_5678, 1'b0, 16'sd0, 16'sd0},
      '{32'hEDCB_A987, 1'b0, 16'sd0, 16'sd0},
      '{32'h0001_0000, 1'b0, 16'sd0, 16'sd0},
      '{32'hFFFF_0000, 1'b0, 16'sd0, 16'sd0}
    };
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (key_table[i]) begin
      if (key_table[i].typed) begin
        pt.key = key_table[i].key;
        pt.h = key_table[i].h;
        pt.v = key_table[i].v;
      end else begin
        pt = circle_point(key_table[i].key);
      end
      send_key(key_table[i].key, pt);
    end
    wait_all_points();

    for (int n = 0; n < RANDOM_KEYS; n++) begin
      // Alternate stretches with random gaps and stretches sent back to back.
      if (n % 150 == 0) no_gaps = (n / 150) % 2 == 1;
      if (n == RANDOM_KEYS / 2) wait_all_points();
      if ($urandom_range(0, 3) == 0) begin
        // Keys close to an octant boundary, on either side of it.
        key = {3'($urandom_range(0, 7)), 29'd0} + 32'($urandom_range(0, 64)) - 32'd32;
      end else begin
        key = $urandom;
      end
      send_key(key, circle_point(key));
    end

    wait_all_points();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    $display("Sent %0d phase keys (axis points, octant boundaries, random phases) and",
             n_keys);
    $display("checked %0d circle points under random input gaps and output stalls.",
             n_points);
    if (n_fail == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
